>>> design/hcm_pkg.sv
// Package for the hotkey chord matcher: table sizes, key and modifier codes,
// request kinds, register map and the search request/response structs.
// Used by all design modules but hcm_checker; depends on nothing.
package hcm_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int CODE_W      = 12;
	localparam int KEY_W       = 8;
	localparam int MOD_W       = 4;

	// Request kinds carried in s_tuser
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_KEY  = 1'b1;

	// Register map: one 32-bit register, index taken from paddr[2]
	localparam int   CFG_ADDR_W      = 3;
	localparam logic REG_TABLE_COUNT = 1'b0;

	// Modifier bits
	localparam logic [MOD_W-1:0] MOD_NONE  = 4'b0000;
	localparam logic [MOD_W-1:0] MOD_SHIFT = 4'b0001;
	localparam logic [MOD_W-1:0] MOD_CTRL  = 4'b0010;
	localparam logic [MOD_W-1:0] MOD_ALT   = 4'b0100;
	localparam logic [MOD_W-1:0] MOD_WIN   = 4'b1000;

	// Virtual key codes of the modifier keys
	localparam logic [KEY_W-1:0] KEY_SHIFT   = 8'h10;
	localparam logic [KEY_W-1:0] KEY_CTRL    = 8'h11;
	localparam logic [KEY_W-1:0] KEY_LWIN    = 8'h5B;
	localparam logic [KEY_W-1:0] KEY_RWIN    = 8'h5C;
	localparam logic [KEY_W-1:0] KEY_LSHIFT  = 8'hA0;
	localparam logic [KEY_W-1:0] KEY_RSHIFT  = 8'hA1;
	localparam logic [KEY_W-1:0] KEY_LCTRL   = 8'hA2;
	localparam logic [KEY_W-1:0] KEY_RCTRL   = 8'hA3;
	localparam logic [KEY_W-1:0] KEY_LALT    = 8'hA4;

	typedef struct packed {
		logic              start;
		logic [CODE_W-1:0] code;
		logic [CNT_W-1:0]  bound;
	} srch_req_t;

	typedef struct packed {
		logic             done;
		logic             hit;
		logic [IDX_W-1:0] index;
	} srch_rsp_t;

	// Map a key code to its modifier bit; ordinary keys give no bit
	function automatic logic [MOD_W-1:0] modifier_of(input logic [KEY_W-1:0] key);
		logic [MOD_W-1:0] m;
		m = MOD_NONE;
		case (key) inside
			KEY_SHIFT, KEY_LSHIFT, KEY_RSHIFT: m = MOD_SHIFT;
			KEY_CTRL, KEY_LCTRL, KEY_RCTRL:    m = MOD_CTRL;
			KEY_LALT:                          m = MOD_ALT;
			KEY_LWIN, KEY_RWIN:                m = MOD_WIN;
			default:                           m = MOD_NONE;
		endcase
		return m;
	endfunction

endpackage

>>> design/hcm_table.sv
// Hotkey table storage: one write port and one read port, read data
// registered. Depends on hcm_pkg.
module hcm_table import hcm_pkg::*; (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [CODE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [CODE_W-1:0] rd_data
);

	logic [CODE_W-1:0] mem_q [TABLE_DEPTH];
	logic [CODE_W-1:0] rd_data_q;

	// Write a loaded entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Register the probed entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/hcm_search.sv
// Binary search sequencer: one shared compare unit, one table read per probe.
// Depends on hcm_pkg; drives the read port of hcm_table.
module hcm_search import hcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  srch_req_t         req,
	output srch_rsp_t         rsp,
	output logic              rd_en,
	output logic [IDX_W-1:0]  rd_addr,
	input  logic [CODE_W-1:0] rd_data
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_CMP  = 3'b100
	} srch_state_t;

	srch_state_t       state_q, state_d;
	logic [CNT_W-1:0]  lo_q, hi_q;
	logic [IDX_W-1:0]  mid_q;
	logic [CODE_W-1:0] code_q;
	logic [CNT_W:0]    sum;
	logic [IDX_W-1:0]  mid;
	logic              open;
	logic              eq, gt;

	// Midpoint of the open range; it stays below hi, so it fits an index
	assign sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid  = sum[IDX_W:1];
	assign open = lo_q < hi_q;

	// Shared compare against the registered probe
	assign eq = code_q == rd_data;
	assign gt = code_q > rd_data;

	assign rd_en   = (state_q == S_READ) && open;
	assign rd_addr = mid;

	// Report a hit on an equal probe, a miss when the range closes
	always_comb begin
		rsp.done  = ((state_q == S_READ) && !open) || ((state_q == S_CMP) && eq);
		rsp.hit   = (state_q == S_CMP) && eq;
		rsp.index = rsp.hit ? mid_q : '0;
	end

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (req.start) state_d = S_READ;
			S_READ:  state_d = open ? S_CMP : S_IDLE;
			S_CMP:   state_d = eq ? S_IDLE : S_READ;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Narrow the range after each probe
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.start) begin
					code_q <= req.code;
					lo_q   <= '0;
					hi_q   <= req.bound;
				end
			end
			S_READ: begin
				mid_q <= mid;
			end
			S_CMP: begin
				if (gt) begin
					lo_q <= {1'b0, mid_q} + CNT_W'(1);
				end else if (!eq) begin
					hi_q <= {1'b0, mid_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/hotkey_chord_matcher.sv
// Hotkey chord matcher top level: stream ports, APB register, modifier mask,
// output register. Depends on hcm_pkg, hcm_table and hcm_search.
// Loads, releases and modifier presses skip the search; an ordinary key press runs
// the binary search, which ends on a hit or when the range closes. Each probe is
// a table read state followed by a compare state. One item at a time: s_tready
// returns the cycle the result enters the output register. Reset clears the
// modifier mask and table_count; table contents are undefined until loaded.
module hotkey_chord_matcher import hcm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // entry_index[5:0], entry_code[17:6],
	                                         // key_code[25:18], key_up[26], zero
	input  logic                  s_tuser,   // req_type
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // matched[0], match_index[6:1],
	                                         // pass_on[7], modifiers_now[11:8], zero
	// Configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_SRCH = 3'b010,
		T_FIN  = 3'b100
	} top_state_t;

	top_state_t        state_q;
	logic [MOD_W-1:0]  mask_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic [15:0]       out_data_q;
	logic              hit_q;
	logic [IDX_W-1:0]  index_q;
	logic              pass_q;

	logic              accept;
	logic              req_type;
	logic [IDX_W-1:0]  entry_index;
	logic [CODE_W-1:0] entry_code;
	logic [KEY_W-1:0]  key_code;
	logic              key_up;
	logic [MOD_W-1:0]  key_mod;
	logic              out_free;
	logic              cfg_wr;
	srch_req_t         sreq;
	srch_rsp_t         srsp;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [CODE_W-1:0] rd_data;

	// Unpack the input item
	assign req_type    = s_tuser;
	assign entry_index = s_tdata[5:0];
	assign entry_code  = s_tdata[17:6];
	assign key_code    = s_tdata[25:18];
	assign key_up      = s_tdata[26];
	assign key_mod     = modifier_of(key_code);

	assign s_tready = (state_q == T_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Start a search for an ordinary key press
	always_comb begin
		sreq.start = accept && (req_type == REQ_KEY) && !key_up && (key_mod == MOD_NONE);
		sreq.code  = {mask_q, key_code};
		sreq.bound = (count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_q;
	end

	hcm_table u_table (
		.clk     (clk),
		.wr_en   (accept && (req_type == REQ_LOAD)),
		.wr_addr (entry_index),
		.wr_data (entry_code),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	hcm_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (sreq),
		.rsp     (srsp),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_COUNT);
	assign prdata = (paddr[2] == REG_TABLE_COUNT) ? {{(32-CNT_W){1'b0}}, count_q} : '0;

	// Control state: sequencer, modifier mask, count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			mask_q      <= MOD_NONE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				count_q <= pwdata[CNT_W-1:0];
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= sreq.start ? T_SRCH : T_FIN;
						if (req_type == REQ_KEY) begin
							if (key_up) begin
								mask_q <= mask_q & ~key_mod;
							end else begin
								mask_q <= mask_q | key_mod;
							end
						end
					end
				end
				T_SRCH: if (srsp.done) state_q <= T_FIN;
				T_FIN:  if (out_free) state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
			if ((state_q == T_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: hold per-item outcome, then load the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q   <= 1'b0;
			index_q <= '0;
			pass_q  <= (req_type == REQ_KEY);
		end
		if ((state_q == T_SRCH) && srsp.done) begin
			hit_q   <= srsp.hit;
			index_q <= srsp.index;
			pass_q  <= !srsp.hit;
		end
		if ((state_q == T_FIN) && out_free) begin
			out_data_q <= {4'b0000, mask_q, pass_q, index_q, hit_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> design/hcm_checker.sv
// Port-level checks for the hotkey chord matcher, bound to the top level.
// Depends only on the top level's ports.
module hcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// Stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One item in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after accept");

	// A match consumes the key event
	a_match_consumes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[7])
		else $error("matched item also passed on");

	// No match reports slot zero
	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0)
		else $error("nonzero index without a match");

endmodule

bind hotkey_chord_matcher hcm_checker u_hcm_checker (.*);

>>> tb/sv/testbench.sv
// Testbench for hotkey_chord_matcher: loads sorted and unsorted hotkey tables,
// plays chords of modifier and key events under random idling, and checks every
// result item. Depends on hcm_pkg and the hotkey_chord_matcher top level.
module testbench;
	import hcm_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 40;

	typedef struct {
		logic              req_type;
		logic [IDX_W-1:0]  slot;
		logic [CODE_W-1:0] code;
		logic [KEY_W-1:0]  key;
		logic              up;
	} hotkey_req_t;

	// Same bit order as m_tdata[11:0]
	typedef struct packed {
		logic [MOD_W-1:0] mods_now;
		logic             pass_on;
		logic [IDX_W-1:0] index;
		logic             matched;
	} chord_result_t;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_CHOKE} rx_mode_e;

	// Predicts the lookup for each accepted item and checks result items in order
	class chord_scoreboard;
		logic [CODE_W-1:0] hotkey_table [TABLE_DEPTH];
		logic [MOD_W-1:0]  held_mods;
		logic [6:0]        table_count;
		chord_result_t     pending_results [$];
		int                errors;

		function new();
			held_mods   = MOD_NONE;
			table_count = '0;
			errors      = 0;
		endfunction

		function logic [MOD_W-1:0] key_modifier(logic [KEY_W-1:0] key);
			case (key)
				KEY_SHIFT, KEY_LSHIFT, KEY_RSHIFT: return MOD_SHIFT;
				KEY_CTRL, KEY_LCTRL, KEY_RCTRL:    return MOD_CTRL;
				KEY_LALT:                          return MOD_ALT;
				KEY_LWIN, KEY_RWIN:                return MOD_WIN;
				default:                           return MOD_NONE;
			endcase
		endfunction

		function void note_item(hotkey_req_t req);
			chord_result_t     r;
			logic [MOD_W-1:0]  m;
			logic [CODE_W-1:0] value;
			int                lo;
			int                hi;
			int                mid;
			r = '0;
			if (req.req_type == REQ_LOAD) begin
				hotkey_table[req.slot] = req.code;
			end else begin
				m = key_modifier(req.key);
				r.pass_on = 1'b1;
				if (req.up) begin
					held_mods = held_mods & ~m;
				end else if (m != MOD_NONE) begin
					held_mods = held_mods | m;
				end else begin
					// Binary search over the first table_count entries, capped at depth
					value = {held_mods, req.key};
					lo = 0;
					hi = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
					while (lo < hi) begin
						mid = (lo + hi) / 2;
						if (value > hotkey_table[mid]) begin
							lo = mid + 1;
						end else if (value < hotkey_table[mid]) begin
							hi = mid;
						end else begin
							r.matched = 1'b1;
							r.index   = mid[IDX_W-1:0];
							r.pass_on = 1'b0;
							break;
						end
					end
				end
			end
			r.mods_now = held_mods;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [15:0] data);
			chord_result_t got;
			chord_result_t want;
			got = data[11:0];
			if (pending_results.size() == 0) begin
				$error("result item with none expected: %h", data);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.matched !== want.matched) begin
				$error("matched: expected %0d, got %0d", want.matched, got.matched);
				errors++;
			end
			if (got.index !== want.index) begin
				$error("match_index: expected %0d, got %0d", want.index, got.index);
				errors++;
			end
			if (got.pass_on !== want.pass_on) begin
				$error("pass_on: expected %0d, got %0d", want.pass_on, got.pass_on);
				errors++;
			end
			if (got.mods_now !== want.mods_now) begin
				$error("modifiers_now: expected %h, got %h", want.mods_now, got.mods_now);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [31:0]           s_tdata;   // entry_index[5:0], entry_code[17:6],
	                                  // key_code[25:18], key_up[26], zero
	logic                  s_tuser;   // req_type
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;   // matched[0], match_index[6:1],
	                                  // pass_on[7], modifiers_now[11:8], zero
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	chord_scoreboard sb;
	int              burst_left;
	int              items_sent;
	int              cycle_count;
	rx_mode_e        rx_mode = RX_OPEN;
	int              rx_left = 0;

	hotkey_chord_matcher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Build a load item; key fields carry random filler
	function automatic hotkey_req_t load_item(int slot, int code);
		hotkey_req_t req;
		req.req_type = REQ_LOAD;
		req.slot     = slot[IDX_W-1:0];
		req.code     = code[CODE_W-1:0];
		req.key      = $urandom_range(0, 255);
		req.up       = $urandom_range(0, 1);
		return req;
	endfunction

	// Build a key event; table fields carry random filler
	function automatic hotkey_req_t key_item(int key, bit up);
		hotkey_req_t req;
		req.req_type = REQ_KEY;
		req.slot     = $urandom_range(0, TABLE_DEPTH - 1);
		req.code     = $urandom_range(0, 4095);
		req.key      = key[KEY_W-1:0];
		req.up       = up;
		return req;
	endfunction

	// Pick one of the key codes that drive modifier bit b
	function automatic logic [KEY_W-1:0] modifier_key(int b);
		int pick;
		pick = $urandom_range(0, 2);
		case (b)
			0:       return (pick == 0) ? KEY_SHIFT : (pick == 1) ? KEY_LSHIFT : KEY_RSHIFT;
			1:       return (pick == 0) ? KEY_CTRL : (pick == 1) ? KEY_LCTRL : KEY_RCTRL;
			2:       return KEY_LALT;
			default: return (pick == 0) ? KEY_LWIN : KEY_RWIN;
		endcase
	endfunction

	// Present one item in bursts with random gaps; return at the accepting edge
	task automatic send_item(hotkey_req_t req);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req.req_type;
		s_tdata  <= {5'b0, req.up, req.key, req.code, req.slot};
		do @(posedge clk); while (!s_tready);
		sb.note_item(req);
		burst_left--;
		items_sent++;
	endtask

	// Drop valid and wait until every expected result item has come out
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write table_count while the block is idle
	task automatic write_count(int value);
		drain_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_TABLE_COUNT, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.table_count = value[6:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Set the modifiers that a target code needs, press its key, maybe release it
	task automatic play_chord(int bound);
		logic [CODE_W-1:0] target;
		if (bound > 0 && $urandom_range(0, 9) != 0)
			target = sb.hotkey_table[$urandom_range(0, bound - 1)];
		else
			target = $urandom_range(0, 4095);
		for (int b = 0; b < MOD_W; b++) begin
			if (sb.held_mods[b] != target[KEY_W + b])
				send_item(key_item(modifier_key(b), !target[KEY_W + b]));
		end
		send_item(key_item(target[KEY_W-1:0], 1'b0));
		if ($urandom_range(0, 1))
			send_item(key_item(target[KEY_W-1:0], 1'b1));
	endtask

	// One random step: mostly chords, the rest stray keys, modifiers and loads
	task automatic random_step(int bound);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			play_chord(bound);
		else if (pick < 85)
			send_item(key_item($urandom_range(0, 255), $urandom_range(0, 1)));
		else if (pick < 95)
			send_item(key_item(modifier_key($urandom_range(0, 3)), $urandom_range(0, 1)));
		else
			send_item(load_item($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 4095)));
	endtask

	// Set a count, load the searched prefix of the table, then run random items
	task automatic run_phase(int count, bit unsorted);
		int bound;
		int step_max;
		int code;
		int start;
		write_count(count);
		bound    = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
		step_max = (bound > 0) ? (4096 - bound) / bound : 0;
		code     = 0;
		for (int i = 0; i < bound; i++) begin
			if (unsorted)
				code = $urandom_range(0, 4095);
			else if (i == 0)
				code = $urandom_range(0, step_max);
			else
				code = code + 1 + $urandom_range(0, step_max);
			send_item(load_item(i, code));
		end
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) random_step(bound);
	endtask

	// Receiver stalls on its own pattern of open, random and choked stretches
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 2));
			rx_left = $urandom_range(4, 40);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_RANDOM: m_tready <= $urandom_range(0, 1);
			default:   m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Check each accepted result item
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// End the run if it hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		sb         = new();
		burst_left = 0;
		items_sent = 0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = REQ_LOAD;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: search with an empty table, then the code extremes
		send_item(key_item(8'h41, 1'b0));
		write_count(2);
		send_item(load_item(0, 12'h000));
		send_item(load_item(1, 12'hFFF));
		send_item('{REQ_LOAD, 6'h3F, 12'hFFF, 8'hFF, 1'b1});
		send_item(key_item(8'h00, 1'b0));
		// Hold all four modifiers and hit the top code
		send_item(key_item(KEY_SHIFT, 1'b0));
		send_item(key_item(KEY_RCTRL, 1'b0));
		send_item(key_item(KEY_LALT, 1'b0));
		send_item(key_item(KEY_RWIN, 1'b0));
		send_item(key_item(8'hFF, 1'b0));
		// Ordinary key release, right alt as a plain key, repeated modifier press
		send_item(key_item(8'hFF, 1'b1));
		send_item(key_item(8'hA5, 1'b0));
		send_item(key_item(KEY_RSHIFT, 1'b0));
		// Release through the other codes where a modifier has them, and one not held
		send_item(key_item(KEY_LSHIFT, 1'b1));
		send_item(key_item(KEY_CTRL, 1'b1));
		send_item(key_item(KEY_LALT, 1'b1));
		send_item(key_item(KEY_LWIN, 1'b1));
		send_item(key_item(KEY_LCTRL, 1'b1));
		send_item(key_item(KEY_LSHIFT, 1'b0));
		send_item(key_item(KEY_LCTRL, 1'b0));
		send_item(key_item(KEY_LWIN, 1'b0));
		send_item(key_item(KEY_SHIFT, 1'b1));
		send_item(key_item(KEY_RCTRL, 1'b1));
		send_item(key_item(KEY_RWIN, 1'b1));

		// Random phases over several counts, including empty, full and oversized
		run_phase(1, 1'b0);
		run_phase(64, 1'b0);
		run_phase(127, 1'b0);
		run_phase(0, 1'b0);
		run_phase(9, 1'b0);
		run_phase(65, 1'b0);
		run_phase(40, 1'b1);
		run_phase($urandom_range(1, 64), 1'b0);

		drain_results();
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> hotkey_chord_matcher.f
design/hcm_pkg.sv
design/hcm_table.sv
design/hcm_search.sv
design/hotkey_chord_matcher.sv
design/hcm_checker.sv
tb/sv/testbench.sv
